FILE: src/dotq_pkg.sv
// ============================================================================
// dotq_pkg: shared types and codes for the deadline ordered task queue
// Request and response payloads, command and status codes, and the
// control and status bundles between the controller and the datapath.
// ============================================================================
package dotq_pkg;

    // default sizing
    localparam int DEPTH_DEFAULT   = 16;
    localparam int ID_BITS_DEFAULT = 8;

    // request command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // response status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // request payload
    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  task_id;
        logic [31:0] deadline;
    } req_t;

    // response payload
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  entry_task;
        logic [31:0] entry_deadline;
        logic [4:0]  occupancy;
        logic        head_valid;
        logic [7:0]  head_task;
    } rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // capture the request
        logic init;        // set up the walk index
        logic rd;          // read slot at walk index
        logic ins_shift;   // move read slot one place toward the tail
        logic ins_place;   // write new task after the read slot
        logic ins_place0;  // write new task at the head slot
        logic rem_eval;    // check read slot for match, close the gap behind
        logic rem_close;   // finish removal, settle status and count
        logic set_full;    // insert rejected
        logic set_empty;   // pop or remove on empty queue
        logic set_unused;  // unknown command, no change
        logic head_rd;     // read head slot
        logic head_cap;    // capture head task
        logic publish;     // load the response register
    } dotq_ctrl_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] command;
        logic       full;
        logic       empty;
        logic       later;     // read slot deadline is later than new one
        logic       idx_zero;
        logic       idx_last;
        logic       out_busy;
    } dotq_stat_t;

endpackage

FILE: src/dotq_ram.sv
// ============================================================================
// dotq_ram: generic single write, single read memory
// One write port and one read port, read data registered.
// ============================================================================
module dotq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/dotq_datapath.sv
// ============================================================================
// dotq_datapath: slot memory, walk index, count and response register
// Carries out the controller's commands one slot access per cycle.
// ============================================================================
module dotq_datapath #(
    parameter int DEPTH   = dotq_pkg::DEPTH_DEFAULT,
    parameter int ID_BITS = dotq_pkg::ID_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dotq_pkg::req_t      in_data,
    input  dotq_pkg::dotq_ctrl_t ctrl,
    output dotq_pkg::dotq_stat_t stat,
    output logic                out_valid,
    input  logic                out_ready,
    output dotq_pkg::rsp_t      out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ID_BITS + 32;

    // latched request
    logic [1:0]         cmd_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [31:0]        dl_reg;

    // walk and queue state
    logic [AW-1:0]      idx_reg;
    logic [CW-1:0]      count_reg;
    logic               found_reg;

    // response fields under construction
    logic [1:0]         res_status_reg;
    logic [ID_BITS-1:0] res_task_reg;
    logic [31:0]        res_dl_reg;
    logic               head_valid_reg;
    logic [ID_BITS-1:0] head_id_reg;

    // response register
    logic               out_valid_reg;
    dotq_pkg::rsp_t     out_data_reg;

    // memory ports
    logic               we;
    logic [AW-1:0]      waddr;
    logic [SW-1:0]      wdata;
    logic               re;
    logic [AW-1:0]      raddr;
    logic [SW-1:0]      rdata;

    logic [ID_BITS-1:0] rd_id;
    logic [31:0]        rd_dl;
    logic               match_now;
    logic [CW-1:0]      last_idx;

    assign rd_id = rdata[SW-1:32];
    assign rd_dl = rdata[31:0];

    assign last_idx  = count_reg - CW'(1);
    assign match_now = !found_reg && ((cmd_reg == dotq_pkg::CMD_POP) || (rd_id == id_reg));

    dotq_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // memory access selection
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg + AW'(1);
        wdata = rdata;
        re    = 1'b0;
        raddr = idx_reg;
        if (ctrl.ins_shift)
        begin
            we = 1'b1;
        end
        if (ctrl.ins_place)
        begin
            we    = 1'b1;
            wdata = {id_reg, dl_reg};
        end
        if (ctrl.ins_place0)
        begin
            we    = 1'b1;
            waddr = '0;
            wdata = {id_reg, dl_reg};
        end
        if (ctrl.rem_eval && found_reg)
        begin
            we    = 1'b1;
            waddr = idx_reg - AW'(1);
        end
        if (ctrl.rd)
        begin
            re = 1'b1;
        end
        if (ctrl.head_rd)
        begin
            re    = (count_reg != '0);
            raddr = '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.init)
            begin
                found_reg <= 1'b0;
            end
            if (ctrl.rem_eval && match_now)
            begin
                found_reg <= 1'b1;
            end
            if (ctrl.ins_place || ctrl.ins_place0)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (ctrl.rem_close && found_reg)
            begin
                count_reg <= count_reg - CW'(1);
            end
            if (ctrl.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request, walk index and response fields
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= in_data.command;
            id_reg  <= ID_BITS'(in_data.task_id);
            dl_reg  <= in_data.deadline;
        end
        if (ctrl.init)
        begin
            idx_reg <= (cmd_reg == dotq_pkg::CMD_INSERT) ? AW'(last_idx) : '0;
        end
        if (ctrl.ins_shift)
        begin
            idx_reg <= idx_reg - AW'(1);
        end
        if (ctrl.rem_eval)
        begin
            idx_reg <= idx_reg + AW'(1);
            if (match_now)
            begin
                res_task_reg <= rd_id;
                res_dl_reg   <= rd_dl;
            end
        end
        if (ctrl.ins_place || ctrl.ins_place0)
        begin
            res_status_reg <= dotq_pkg::ST_OK;
            res_task_reg   <= id_reg;
            res_dl_reg     <= dl_reg;
        end
        if (ctrl.set_full)
        begin
            res_status_reg <= dotq_pkg::ST_FULL;
            res_task_reg   <= id_reg;
            res_dl_reg     <= dl_reg;
        end
        if (ctrl.set_empty)
        begin
            res_status_reg <= dotq_pkg::ST_EMPTY;
            res_task_reg   <= (cmd_reg == dotq_pkg::CMD_REMOVE) ? id_reg : '0;
            res_dl_reg     <= '0;
        end
        if (ctrl.set_unused)
        begin
            res_status_reg <= dotq_pkg::ST_OK;
            res_task_reg   <= '0;
            res_dl_reg     <= '0;
        end
        if (ctrl.rem_close)
        begin
            if (found_reg)
            begin
                res_status_reg <= dotq_pkg::ST_OK;
            end
            else
            begin
                res_status_reg <= dotq_pkg::ST_NOT_FOUND;
                res_task_reg   <= id_reg;
                res_dl_reg     <= '0;
            end
        end
        if (ctrl.head_cap)
        begin
            head_valid_reg <= (count_reg != '0);
            head_id_reg    <= (count_reg != '0) ? rd_id : '0;
        end
        if (ctrl.publish)
        begin
            out_data_reg.status         <= res_status_reg;
            out_data_reg.entry_task     <= 8'(res_task_reg);
            out_data_reg.entry_deadline <= res_dl_reg;
            out_data_reg.occupancy      <= 5'(count_reg);
            out_data_reg.head_valid     <= head_valid_reg;
            out_data_reg.head_task      <= 8'(head_id_reg);
        end
    end

    // status back to the controller
    always_comb
    begin
        stat.command  = cmd_reg;
        stat.full     = (count_reg == CW'(DEPTH));
        stat.empty    = (count_reg == '0);
        stat.later    = (rd_dl > dl_reg);
        stat.idx_zero = (idx_reg == '0);
        stat.idx_last = (CW'(idx_reg) == last_idx);
        stat.out_busy = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // count stays in range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    // insert writes stay inside the held region plus one
    a_ins_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.ins_shift || ctrl.ins_place) |-> (CW'(idx_reg) + CW'(1) <= count_reg))
        else $error("insert write past end of queue");

    // count moves by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((count_reg == $past(count_reg))
               || (count_reg == $past(count_reg) + CW'(1))
               || (count_reg + CW'(1) == $past(count_reg))))
        else $error("queue count jumped");

endmodule

FILE: src/dotq_ctrl.sv
// ============================================================================
// dotq_ctrl: command sequencer for the deadline ordered task queue
// Walks the slot memory for insert and removal, then reads the head and
// hands the response to the output register.
// ============================================================================
module dotq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dotq_pkg::dotq_stat_t stat,
    output dotq_pkg::dotq_ctrl_t ctrl
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_INS_RD   = 4'd2;
    localparam logic [3:0] S_INS_EV   = 4'd3;
    localparam logic [3:0] S_INS_PUT0 = 4'd4;
    localparam logic [3:0] S_REM_RD   = 4'd5;
    localparam logic [3:0] S_REM_EV   = 4'd6;
    localparam logic [3:0] S_REM_CLS  = 4'd7;
    localparam logic [3:0] S_HEAD_RD  = 4'd8;
    localparam logic [3:0] S_HEAD_EV  = 4'd9;
    localparam logic [3:0] S_FINISH   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                ctrl.init = 1'b1;
                unique case (stat.command)
                    dotq_pkg::CMD_INSERT:
                    begin
                        if (stat.full)
                        begin
                            ctrl.set_full = 1'b1;
                            state_next    = S_HEAD_RD;
                        end
                        else if (stat.empty)
                        begin
                            state_next = S_INS_PUT0;
                        end
                        else
                        begin
                            state_next = S_INS_RD;
                        end
                    end
                    dotq_pkg::CMD_POP, dotq_pkg::CMD_REMOVE:
                    begin
                        if (stat.empty)
                        begin
                            ctrl.set_empty = 1'b1;
                            state_next     = S_HEAD_RD;
                        end
                        else
                        begin
                            state_next = S_REM_RD;
                        end
                    end
                    default:
                    begin
                        ctrl.set_unused = 1'b1;
                        state_next      = S_HEAD_RD;
                    end
                endcase
            end
            S_INS_RD:
            begin
                ctrl.rd    = 1'b1;
                state_next = S_INS_EV;
            end
            S_INS_EV:
            begin
                // later deadline moves down, otherwise the new task lands behind it
                if (stat.later)
                begin
                    ctrl.ins_shift = 1'b1;
                    state_next     = stat.idx_zero ? S_INS_PUT0 : S_INS_RD;
                end
                else
                begin
                    ctrl.ins_place = 1'b1;
                    state_next     = S_HEAD_RD;
                end
            end
            S_INS_PUT0:
            begin
                ctrl.ins_place0 = 1'b1;
                state_next      = S_HEAD_RD;
            end
            S_REM_RD:
            begin
                ctrl.rd    = 1'b1;
                state_next = S_REM_EV;
            end
            S_REM_EV:
            begin
                ctrl.rem_eval = 1'b1;
                state_next    = stat.idx_last ? S_REM_CLS : S_REM_RD;
            end
            S_REM_CLS:
            begin
                ctrl.rem_close = 1'b1;
                state_next     = S_HEAD_RD;
            end
            S_HEAD_RD:
            begin
                ctrl.head_rd = 1'b1;
                state_next   = S_HEAD_EV;
            end
            S_HEAD_EV:
            begin
                ctrl.head_cap = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                // wait for room in the response register
                if (!stat.out_busy)
                begin
                    ctrl.publish = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    // response only loads into a free register
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.publish |-> !stat.out_busy)
        else $error("response loaded over a pending one");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while busy");

    // removal walk only begins on a non-empty queue
    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DISPATCH && state_next == S_REM_RD) |-> !stat.empty)
        else $error("removal walk on empty queue");

endmodule

FILE: src/deadline_ordered_task_queue.sv
// ============================================================================
// deadline_ordered_task_queue: earliest deadline first ready queue
// Sorted task queue with insert, pop head and remove by id.
// ============================================================================
// usage
//   in_valid / in_ready / in_data carry one request: insert a task with its
//   deadline, pop the earliest deadline, or remove the first task matching
//   an id. ties in deadline leave in arrival order.
//   out_valid / out_ready / out_data return one response per request with
//   status, the entry concerned, the new occupancy and the new head task.
// request handling
//   one request at a time. the sequencer touches one slot of the single
//   read port memory at a time: insert walks from the tail toward its
//   place, pop and remove walk the whole held region, then the head
//   slot is read. rejected inserts, pop or remove on an empty queue and
//   the unused code go straight to the head read; insert into an empty
//   queue writes the head slot with no walk.
// reset
//   the queue comes up empty with no response pending; slot contents are
//   not cleared and are only read below the held count.
// stall
//   a response waits in the output register while out_ready is low; the
//   next request is taken meanwhile and holds only at its own response.
// ============================================================================
module deadline_ordered_task_queue #(
    parameter int DEPTH   = dotq_pkg::DEPTH_DEFAULT,
    parameter int ID_BITS = dotq_pkg::ID_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dotq_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output dotq_pkg::rsp_t out_data
);

    dotq_pkg::dotq_ctrl_t ctrl;
    dotq_pkg::dotq_stat_t stat;

    // sequencer
    dotq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // slot storage and response path
    dotq_datapath #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .ctrl      (ctrl),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: tb/tb_deadline_ordered_task_queue.sv
// ============================================================================
// tb_deadline_ordered_task_queue: self-checking bench for the EDF ready queue
// Drives insert, pop, remove-by-id and unused-code requests with random gaps
// and output stalls, keeps its own sorted copy of the queue to predict each
// response, and compares every response field by field in arrival order.
// ============================================================================
module tb_deadline_ordered_task_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import dotq_pkg::*;

    localparam int         QUEUE_DEPTH     = DEPTH_DEFAULT;
    localparam int         HALF_PERIOD     = 2;
    localparam int         RESET_CYCLES    = 9;
    localparam int         RANDOM_REQUESTS = 826;
    localparam int         SETTLE_CYCLES   = 60;
    localparam int         IDLE_PCT        = 17;
    localparam logic [1:0] CMD_UNUSED      = 2'd3;

    // mix of operations in the random part
    typedef enum int {LEAN_FILL, LEAN_EVEN, LEAN_DRAIN} lean_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] deadline;
    } slot_t;

    // sorted copy of the queue plus the responses still owed
    class ready_list_model;
        slot_t sorted_tasks[$];
        rsp_t  pending_rsp[$];
        int    mismatches = 0;

        function int outstanding();
            return pending_rsp.size();
        endfunction

        // work out the response to an accepted request
        function void note_request(req_t r);
            rsp_t  want;
            slot_t ent;
            int    pos;
            want         = '0;
            ent.id       = r.task_id;
            ent.deadline = r.deadline;
            case (r.command)
                CMD_INSERT:
                begin
                    want.entry_task     = r.task_id;
                    want.entry_deadline = r.deadline;
                    if (sorted_tasks.size() >= QUEUE_DEPTH)
                    begin
                        want.status = ST_FULL;
                    end
                    else
                    begin
                        // goes after every entry with an equal or earlier deadline
                        pos = 0;
                        while (pos < sorted_tasks.size() &&
                               sorted_tasks[pos].deadline <= r.deadline)
                            pos++;
                        sorted_tasks.insert(pos, ent);
                        want.status = ST_OK;
                    end
                end
                CMD_POP:
                begin
                    if (sorted_tasks.size() == 0)
                    begin
                        want.status = ST_EMPTY;
                    end
                    else
                    begin
                        want.status         = ST_OK;
                        want.entry_task     = sorted_tasks[0].id;
                        want.entry_deadline = sorted_tasks[0].deadline;
                        void'(sorted_tasks.pop_front());
                    end
                end
                CMD_REMOVE:
                begin
                    want.entry_task = r.task_id;
                    if (sorted_tasks.size() == 0)
                    begin
                        want.status = ST_EMPTY;
                    end
                    else
                    begin
                        // first match counted from the head
                        pos = 0;
                        while (pos < sorted_tasks.size() && sorted_tasks[pos].id != r.task_id)
                            pos++;
                        if (pos == sorted_tasks.size())
                        begin
                            want.status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            want.status         = ST_OK;
                            want.entry_deadline = sorted_tasks[pos].deadline;
                            sorted_tasks.delete(pos);
                        end
                    end
                end
                default:
                begin
                    // unused code: queue unchanged, entry fields stay zero
                end
            endcase
            want.occupancy = 5'(sorted_tasks.size());
            if (sorted_tasks.size() != 0)
            begin
                want.head_valid = 1'b1;
                want.head_task  = sorted_tasks[0].id;
            end
            pending_rsp.push_back(want);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        // compare one accepted response with the oldest expectation
        function void check_response(rsp_t got);
            rsp_t want;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                $display("%0t: response with none expected, expected nothing, actual %h",
                         $time, got);
                return;
            end
            want = pending_rsp.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("entry_task", 32'(want.entry_task), 32'(got.entry_task));
            compare_field("entry_deadline", want.entry_deadline, got.entry_deadline);
            compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
            compare_field("head_valid", 32'(want.head_valid), 32'(got.head_valid));
            compare_field("head_task", 32'(want.head_task), 32'(got.head_task));
        endfunction
    endclass

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_ready;
    req_t            in_data   = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    rsp_t            out_data;
    logic            quiet     = 1'b0;
    ready_list_model ledger;

    deadline_ordered_task_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    always #(HALF_PERIOD) clk = ~clk;

    // response side stalls at random except in the quiet stretch
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // response checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            ledger.check_response(out_data);
    end

    // hard limit on the run
    initial
    begin
        #2_000_000;
        $display("** deadline_ordered_task_queue: FAILED **");
        $finish;
    end

    function automatic req_t make_req(logic [1:0] cmd, logic [7:0] id, logic [31:0] dl);
        req_t r;
        r.command  = cmd;
        r.task_id  = id;
        r.deadline = dl;
        return r;
    endfunction

    // random request, weighted by the current lean
    function automatic req_t next_request(lean_t lean);
        req_t r;
        int   roll;
        int   ins_pct;
        int   pop_pct;
        int   held;
        case (lean)
            LEAN_FILL:
            begin
                ins_pct = 70;
                pop_pct = 12;
            end
            LEAN_DRAIN:
            begin
                ins_pct = 15;
                pop_pct = 45;
            end
            default:
            begin
                ins_pct = 45;
                pop_pct = 25;
            end
        endcase
        roll = $urandom_range(99);
        if (roll < 3)
            r.command = CMD_UNUSED;
        else if (roll < 3 + ins_pct)
            r.command = CMD_INSERT;
        else if (roll < 3 + ins_pct + pop_pct)
            r.command = CMD_POP;
        else
            r.command = CMD_REMOVE;

        // small id pool gives duplicates, the rest spans all bits
        r.task_id = ($urandom_range(1) == 0) ? 8'($urandom_range(7)) : 8'($urandom);

        // small deadlines give ties, plus extremes and full range
        roll = $urandom_range(19);
        if (roll < 8)
            r.deadline = 32'($urandom_range(15));
        else if (roll == 8)
            r.deadline = 32'h0000_0000;
        else if (roll == 9)
            r.deadline = 32'hFFFF_FFFF;
        else if (roll == 10)
            r.deadline = 32'hFFFF_FFF0 | 32'($urandom_range(15));
        else
            r.deadline = $urandom;

        // removes mostly aim at a held task
        held = ledger.sorted_tasks.size();
        if (r.command == CMD_REMOVE && held != 0 && $urandom_range(9) < 7)
            r.task_id = ledger.sorted_tasks[$urandom_range(held - 1)].id;
        return r;
    endfunction

    // offer one request, with random idle cycles ahead of it
    task automatic send_request(req_t r);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ledger.note_request(r);
    endtask

    // empty cases, a full fill with ties and duplicates, then edge cases
    task automatic run_directed();
        int          i;
        logic [7:0]  id;
        logic [31:0] dl;
        send_request(make_req(CMD_POP, 8'hFF, 32'hFFFF_FFFF));
        send_request(make_req(CMD_REMOVE, 8'hAB, 32'h0000_0000));
        send_request(make_req(CMD_UNUSED, 8'h00, 32'h0000_0000));
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin
            id = (i == 9) ? 8'h11 : 8'(i * 17);
            case (i % 4)
                0:       dl = 32'hFFFF_FFFF;
                1:       dl = 32'h0000_0000;
                2:       dl = 32'h8000_0000;
                default: dl = 32'h7FFF_FFFF;
            endcase
            send_request(make_req(CMD_INSERT, id, dl));
        end
        send_request(make_req(CMD_INSERT, 8'hC3, 32'h1234_5678));
        send_request(make_req(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF));
        send_request(make_req(CMD_REMOVE, 8'h3C, 32'h0000_0000));
        send_request(make_req(CMD_REMOVE, 8'h11, 32'hFFFF_FFFF));
        send_request(make_req(CMD_POP, 8'h00, 32'h0000_0000));
    endtask

    // main sequence
    initial
    begin
        int    n;
        lean_t lean;
        ledger = new;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        for (n = 0; n < RANDOM_REQUESTS; n++)
        begin
            quiet = (n >= 400 && n < 550);
            // hold off until the queue has answered everything
            if (n == 300 || n == 700)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (ledger.outstanding() != 0)
                    @(posedge clk);
            end
            case ((n / 40) % 4)
                0:       lean = LEAN_FILL;
                2:       lean = LEAN_DRAIN;
                default: lean = LEAN_EVEN;
            endcase
            send_request(next_request(lean));
        end

        @(negedge clk);
        in_valid <= 1'b0;
        quiet = 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (ledger.mismatches == 0)
            $display("** deadline_ordered_task_queue: PASSED **");
        else
            $display("** deadline_ordered_task_queue: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
src/dotq_pkg.sv
src/dotq_ram.sv
src/dotq_datapath.sv
src/dotq_ctrl.sv
src/deadline_ordered_task_queue.sv
tb/tb_deadline_ordered_task_queue.sv
